>>> hdl/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared widths and pipeline payload types for the triangle face normal unit.
// ----------------------------------------------------------------------------
package tfn_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int EDGE_W      = COORD_WIDTH + 1;
	localparam int PROD_W      = 2 * EDGE_W;
	localparam int CROSS_W     = PROD_W + 1;
	localparam int MAG_W       = CROSS_W - 1;
	localparam int SQ_W        = 2 * MAG_W;
	localparam int LEN_W       = SQ_W + 2;
	localparam int NORM_W      = 16;
	localparam int FRAC_W      = NORM_W - 2;
	localparam int QBITS       = NORM_W - 1;
	localparam int QS_W        = LEN_W + QBITS;
	localparam int ACC_W       = LEN_W + 2 * QBITS;
	localparam int BIT_W       = $clog2(QBITS);
	localparam int CROSS_ST    = 3;
	localparam int SQUARE_ST   = 2;
	localparam int NUM_ST      = CROSS_ST + SQUARE_ST + QBITS + 1;

	typedef struct packed {
		logic [2:0][2:0][COORD_WIDTH-1:0] v; // [vertex][axis]
		logic                             last;
	} tri_t;

	typedef struct packed {
		logic [2:0][MAG_W-1:0] mag;
		logic [2:0]            neg;
		logic                  last;
	} cross_t;

	typedef struct packed {
		logic [ACC_W-1:0]  tgt;
		logic [ACC_W-1:0]  p;
		logic [QS_W-1:0]   qs;
		logic [NORM_W-1:0] q;
		logic              neg;
	} comp_t;

	typedef struct packed {
		comp_t [2:0]      c;
		logic [LEN_W-1:0] len2;
		logic             last;
	} iter_t;

endpackage

>>> hdl/tfn_if.sv
// ----------------------------------------------------------------------------
// tfn_if
// Valid/ready channels for triangles in and normals out.
// ----------------------------------------------------------------------------
interface tfn_tri_if;
	logic                            valid;
	logic                            ready;
	logic [tfn_pkg::COORD_WIDTH-1:0] v0_x, v0_y, v0_z;
	logic [tfn_pkg::COORD_WIDTH-1:0] v1_x, v1_y, v1_z;
	logic [tfn_pkg::COORD_WIDTH-1:0] v2_x, v2_y, v2_z;
	logic                            last_tri;

	modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
		v2_x, v2_y, v2_z, last_tri, input ready);
	modport sink (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
		v2_x, v2_y, v2_z, last_tri, output ready);
endinterface

interface tfn_norm_if;
	logic                       valid;
	logic                       ready;
	logic [tfn_pkg::NORM_W-1:0] norm_x, norm_y, norm_z;
	logic                       degenerate;
	logic                       last_out;

	modport source (output valid, norm_x, norm_y, norm_z, degenerate, last_out,
		input ready);
	modport sink (input valid, norm_x, norm_y, norm_z, degenerate, last_out,
		output ready);
endinterface

>>> hdl/triangle_face_normal.sv
// Throughput: one triangle per cycle while no stage stalls; each of the 15
// quotient bits has its own pipeline stage, so nothing is shared between items.
// Stages stall independently; a bubble ahead of a stalled beat is filled.
// Reset clears all stage valid bits; the output holds no beat after reset.
// ----------------------------------------------------------------------------
// triangle_face_normal
// Unit face normal in Q1.14 of a Q4.12 triangle, streaming pipeline.
// ----------------------------------------------------------------------------
module triangle_face_normal (
	input  logic        clk,
	input  logic        arst_n,
	tfn_tri_if.sink     tri_in,
	tfn_norm_if.source  norm_out
);

	localparam int ST_SQ  = tfn_pkg::CROSS_ST;
	localparam int ST_DIV = tfn_pkg::CROSS_ST + tfn_pkg::SQUARE_ST;
	localparam int ST_OUT = tfn_pkg::NUM_ST - 1;

	logic [tfn_pkg::NUM_ST-1:0] vld, en;
	tfn_pkg::tri_t              tri_d;
	tfn_pkg::cross_t            cross_w;
	tfn_pkg::iter_t             iter_w [tfn_pkg::QBITS+1];

	logic [2:0][tfn_pkg::NORM_W-1:0] norm_d, norm_q;
	logic                            deg_d, deg_q, last_q;

	// A stage takes a new beat when empty or when its beat moves on.
	always_comb begin
		en[ST_OUT] = !vld[ST_OUT] || norm_out.ready;
		for (int k = ST_OUT - 1; k >= 0; k--)
			en[k] = !vld[k] || en[k+1];
	end

	assign tri_in.ready = en[0];

	always_comb begin
		tri_d.v[0][0] = tri_in.v0_x;
		tri_d.v[0][1] = tri_in.v0_y;
		tri_d.v[0][2] = tri_in.v0_z;
		tri_d.v[1][0] = tri_in.v1_x;
		tri_d.v[1][1] = tri_in.v1_y;
		tri_d.v[1][2] = tri_in.v1_z;
		tri_d.v[2][0] = tri_in.v2_x;
		tri_d.v[2][1] = tri_in.v2_y;
		tri_d.v[2][2] = tri_in.v2_z;
		tri_d.last    = tri_in.last_tri;
	end

	tfn_cross u_cross (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (tri_in.valid),
		.en        (en[tfn_pkg::CROSS_ST-1:0]),
		.tri_in    (tri_d),
		.vld       (vld[tfn_pkg::CROSS_ST-1:0]),
		.cross_out (cross_w)
	);

	tfn_square u_square (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld[ST_SQ-1]),
		.en       (en[ST_DIV-1:ST_SQ]),
		.cross_in (cross_w),
		.vld      (vld[ST_DIV-1:ST_SQ]),
		.iter_out (iter_w[0])
	);

	for (genvar k = 0; k < tfn_pkg::QBITS; k++) begin : g_step
		tfn_norm_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (vld[ST_DIV+k-1]),
			.en       (en[ST_DIV+k]),
			.step_bit (tfn_pkg::BIT_W'(tfn_pkg::QBITS - 1 - k)),
			.iter_in  (iter_w[k]),
			.vld      (vld[ST_DIV+k]),
			.iter_out (iter_w[k+1])
		);
	end

	// Zero length: every trial passes, so force the normal to zero.
	always_comb begin
		deg_d = (iter_w[tfn_pkg::QBITS].len2 == '0);
		for (int i = 0; i < 3; i++) begin
			if (deg_d)
				norm_d[i] = '0;
			else if (iter_w[tfn_pkg::QBITS].c[i].neg)
				norm_d[i] = -iter_w[tfn_pkg::QBITS].c[i].q;
			else
				norm_d[i] = iter_w[tfn_pkg::QBITS].c[i].q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld[ST_OUT] <= 1'b0;
		end else if (en[ST_OUT]) begin
			vld[ST_OUT] <= vld[ST_OUT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_OUT]) begin
			norm_q <= norm_d;
			deg_q  <= deg_d;
			last_q <= iter_w[tfn_pkg::QBITS].last;
		end
	end

	assign norm_out.valid      = vld[ST_OUT];
	assign norm_out.norm_x     = norm_q[0];
	assign norm_out.norm_y     = norm_q[1];
	assign norm_out.norm_z     = norm_q[2];
	assign norm_out.degenerate = deg_q;
	assign norm_out.last_out   = last_q;

endmodule

>>> hdl/tfn_cross.sv
// ----------------------------------------------------------------------------
// tfn_cross
// Edge vectors, partial products and cross product magnitude/sign (3 stages).
// ----------------------------------------------------------------------------
module tfn_cross (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic [tfn_pkg::CROSS_ST-1:0]          en,
	input  tfn_pkg::tri_t                         tri_in,
	output logic [tfn_pkg::CROSS_ST-1:0]          vld,
	output tfn_pkg::cross_t                       cross_out
);

	logic [2:0][tfn_pkg::EDGE_W-1:0]  ea_s1, eb_s1;
	logic                             last_s1;
	logic [5:0][tfn_pkg::PROD_W-1:0]  prod_s2;
	logic                             last_s2;
	tfn_pkg::cross_t                  cr_s3;

	logic [2:0][tfn_pkg::EDGE_W-1:0]  ea_d, eb_d;
	logic [5:0][tfn_pkg::PROD_W-1:0]  prod_d;
	tfn_pkg::cross_t                  cr_d;
	logic signed [tfn_pkg::CROSS_W-1:0] c_val;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ea_d[i] = $signed({tri_in.v[1][i][tfn_pkg::COORD_WIDTH-1], tri_in.v[1][i]})
				- $signed({tri_in.v[0][i][tfn_pkg::COORD_WIDTH-1], tri_in.v[0][i]});
			eb_d[i] = $signed({tri_in.v[2][i][tfn_pkg::COORD_WIDTH-1], tri_in.v[2][i]})
				- $signed({tri_in.v[0][i][tfn_pkg::COORD_WIDTH-1], tri_in.v[0][i]});
		end
	end

	always_comb begin
		prod_d[0] = tfn_pkg::PROD_W'($signed(ea_s1[1]))
			* tfn_pkg::PROD_W'($signed(eb_s1[2]));
		prod_d[1] = tfn_pkg::PROD_W'($signed(ea_s1[2]))
			* tfn_pkg::PROD_W'($signed(eb_s1[1]));
		prod_d[2] = tfn_pkg::PROD_W'($signed(ea_s1[2]))
			* tfn_pkg::PROD_W'($signed(eb_s1[0]));
		prod_d[3] = tfn_pkg::PROD_W'($signed(ea_s1[0]))
			* tfn_pkg::PROD_W'($signed(eb_s1[2]));
		prod_d[4] = tfn_pkg::PROD_W'($signed(ea_s1[0]))
			* tfn_pkg::PROD_W'($signed(eb_s1[1]));
		prod_d[5] = tfn_pkg::PROD_W'($signed(ea_s1[1]))
			* tfn_pkg::PROD_W'($signed(eb_s1[0]));
	end

	always_comb begin
		cr_d      = '0;
		cr_d.last = last_s2;
		c_val     = '0;
		for (int i = 0; i < 3; i++) begin
			c_val = $signed({prod_s2[2*i][tfn_pkg::PROD_W-1], prod_s2[2*i]})
				- $signed({prod_s2[2*i+1][tfn_pkg::PROD_W-1], prod_s2[2*i+1]});
			cr_d.neg[i] = c_val[tfn_pkg::CROSS_W-1];
			cr_d.mag[i] = c_val[tfn_pkg::CROSS_W-1]
				? tfn_pkg::MAG_W'(-c_val) : tfn_pkg::MAG_W'(c_val);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (en[0]) vld[0] <= in_valid;
			if (en[1]) vld[1] <= vld[0];
			if (en[2]) vld[2] <= vld[1];
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ea_s1   <= ea_d;
			eb_s1   <= eb_d;
			last_s1 <= tri_in.last;
		end
		if (en[1]) begin
			prod_s2 <= prod_d;
			last_s2 <= last_s1;
		end
		if (en[2]) cr_s3 <= cr_d;
	end

	assign cross_out = cr_s3;

endmodule

>>> hdl/tfn_square.sv
// ----------------------------------------------------------------------------
// tfn_square
// Squares of the cross product components and the squared length (2 stages).
// ----------------------------------------------------------------------------
module tfn_square (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic [tfn_pkg::SQUARE_ST-1:0]   en,
	input  tfn_pkg::cross_t                 cross_in,
	output logic [tfn_pkg::SQUARE_ST-1:0]   vld,
	output tfn_pkg::iter_t                  iter_out
);

	logic [2:0][tfn_pkg::SQ_W-1:0] sq_s4;
	logic [2:0]                    neg_s4;
	logic                          last_s4;
	tfn_pkg::iter_t                it_s5;

	logic [2:0][tfn_pkg::SQ_W-1:0] sq_d;
	tfn_pkg::iter_t                it_d;

	always_comb begin
		for (int i = 0; i < 3; i++)
			sq_d[i] = tfn_pkg::SQ_W'(cross_in.mag[i]) * tfn_pkg::SQ_W'(cross_in.mag[i]);
	end

	always_comb begin
		it_d      = '0;
		it_d.last = last_s4;
		it_d.len2 = tfn_pkg::LEN_W'(sq_s4[0]) + tfn_pkg::LEN_W'(sq_s4[1])
			+ tfn_pkg::LEN_W'(sq_s4[2]);
		for (int i = 0; i < 3; i++) begin
			it_d.c[i].tgt = tfn_pkg::ACC_W'(sq_s4[i]) << (2 * tfn_pkg::FRAC_W);
			it_d.c[i].neg = neg_s4[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (en[0]) vld[0] <= in_valid;
			if (en[1]) vld[1] <= vld[0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			sq_s4   <= sq_d;
			neg_s4  <= cross_in.neg;
			last_s4 <= cross_in.last;
		end
		if (en[1]) it_s5 <= it_d;
	end

	assign iter_out = it_s5;

endmodule

>>> hdl/tfn_norm_step.sv
// ----------------------------------------------------------------------------
// tfn_norm_step
// One quotient bit of |c| * 2^14 / sqrt(S) for all three components.
// ----------------------------------------------------------------------------
module tfn_norm_step (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        en,
	input  logic [tfn_pkg::BIT_W-1:0]   step_bit,
	input  tfn_pkg::iter_t              iter_in,
	output logic                        vld,
	output tfn_pkg::iter_t              iter_out
);

	tfn_pkg::iter_t          it_d, it_s1;
	logic [tfn_pkg::ACC_W-1:0] trial;

	// (q + 2^b)^2 S = q^2 S + 2^(b+1) q S + 2^(2b) S
	always_comb begin
		it_d  = iter_in;
		trial = '0;
		for (int i = 0; i < 3; i++) begin
			trial = iter_in.c[i].p
				+ (tfn_pkg::ACC_W'(iter_in.c[i].qs) << (step_bit + 1'b1))
				+ (tfn_pkg::ACC_W'(iter_in.len2) << {step_bit, 1'b0});
			if (trial <= iter_in.c[i].tgt) begin
				it_d.c[i].p  = trial;
				it_d.c[i].qs = iter_in.c[i].qs
					+ (tfn_pkg::QS_W'(iter_in.len2) << step_bit);
				it_d.c[i].q  = iter_in.c[i].q | (tfn_pkg::NORM_W'(1) << step_bit);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= 1'b0;
		end else if (en) begin
			vld <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) it_s1 <= it_d;
	end

	assign iter_out = it_s1;

endmodule
